// ===== rtl/lcp_pkg.sv =====
package lcp_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int COUNT_BITS  = 16;
   localparam int WORD_W      = 32;
   localparam int CAP_W       = 5;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int RANK_W      = IDX_W;
   localparam int USED_W      = $clog2(NUM_ENTRIES + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [RANK_W-1:0]     rank_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [WORD_W-1:0]     word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // How the other valid entries move when the written entry becomes most recent.
   typedef enum logic {
      RANK_BELOW,
      RANK_ALL
   } rank_op_type;

   typedef struct packed {
      logic      valid;
      word_type  key;
      word_type  data;
      count_type count;
      rank_type  rank;
   } entry_type;

   typedef struct packed {
      logic        en;
      idx_type     slot;
      word_type    key;
      word_type    data;
      count_type   count;
      rank_op_type rank_op;
      rank_type    ref_rank;
   } wr_cmd_type;

endpackage

// ===== rtl/lcp_entry_store.sv =====
module lcp_entry_store (
   input  logic                clock,
   input  logic                reset,
   input  lcp_pkg::idx_type    rd_idx,
   output lcp_pkg::entry_type  rd_entry,
   input  lcp_pkg::wr_cmd_type wr_cmd
);
   import lcp_pkg::*;

   logic      valid_ff [NUM_ENTRIES];
   word_type  key_ff   [NUM_ENTRIES];
   word_type  data_ff  [NUM_ENTRIES];
   count_type count_ff [NUM_ENTRIES];
   rank_type  rank_ff  [NUM_ENTRIES];
   rank_type  rank_in  [NUM_ENTRIES];

   // Each entry keeps its own recency rank, which can move when another entry is written.
   always_comb begin
      for (int j = 0; j < NUM_ENTRIES; j++) begin
         rank_in[j] = rank_ff[j];
         if (wr_cmd.en) begin
            if (idx_type'(j) == wr_cmd.slot) begin
               rank_in[j] = '0;
            end else if (valid_ff[j]) begin
               if (wr_cmd.rank_op == RANK_ALL || rank_ff[j] < wr_cmd.ref_rank) begin
                  rank_in[j] = rank_ff[j] + RANK_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (wr_cmd.en) begin
         valid_ff[wr_cmd.slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_ENTRIES; j++) begin
         rank_ff[j] <= rank_in[j];
      end
      if (wr_cmd.en) begin
         key_ff[wr_cmd.slot]   <= wr_cmd.key;
         data_ff[wr_cmd.slot]  <= wr_cmd.data;
         count_ff[wr_cmd.slot] <= wr_cmd.count;
      end
   end

   assign rd_entry.valid = valid_ff[rd_idx];
   assign rd_entry.key   = key_ff[rd_idx];
   assign rd_entry.data  = data_ff[rd_idx];
   assign rd_entry.count = count_ff[rd_idx];
   assign rd_entry.rank  = rank_ff[rd_idx];

endmodule

// ===== rtl/lcp_match_unit.sv =====
module lcp_match_unit (
   input  lcp_pkg::entry_type entry,
   input  lcp_pkg::word_type  key,
   input  logic               best_have,
   input  lcp_pkg::count_type best_count,
   input  lcp_pkg::rank_type  best_rank,
   output logic               key_match,
   output logic               better
);
   import lcp_pkg::*;

   // A lower count wins; on equal counts the older entry (higher rank) wins.
   assign key_match = entry.valid && (entry.key == key);
   assign better    = entry.valid &&
                      (!best_have || (entry.count < best_count) ||
                       ((entry.count == best_count) && (entry.rank > best_rank)));

endmodule

// ===== rtl/lcp_control.sv =====
module lcp_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic signed [31:0]  req_lookup_key,
   input  logic signed [31:0]  req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic signed [31:0]  rsp_read_data,
   output logic                rsp_evicted,
   output logic signed [31:0]  rsp_evicted_key,
   input  logic                csr_write_enable,
   input  logic [4:0]          csr_write_data,
   output lcp_pkg::idx_type    rd_idx,
   input  lcp_pkg::entry_type  rd_entry,
   output lcp_pkg::word_type   match_key,
   input  logic                key_match,
   input  logic                better,
   output logic                best_have,
   output lcp_pkg::count_type  best_count,
   output lcp_pkg::rank_type   best_rank,
   output lcp_pkg::wr_cmd_type wr_cmd
);
   import lcp_pkg::*;

   localparam idx_type IDX_LAST = idx_type'(NUM_ENTRIES - 1);

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_reg_ff, cap_reg_in;
   logic              rsp_valid_ff, rsp_valid_in;

   idx_type           idx_ff, idx_in;
   logic              op_ff, op_in;
   word_type          key_ff, key_in;
   word_type          data_ff, data_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic              found_ff, found_in;
   idx_type           found_idx_ff, found_idx_in;
   word_type          found_data_ff, found_data_in;
   count_type         found_count_ff, found_count_in;
   rank_type          found_rank_ff, found_rank_in;
   logic              victim_ff, victim_in;
   idx_type           victim_idx_ff, victim_idx_in;
   word_type          victim_key_ff, victim_key_in;
   count_type         victim_count_ff, victim_count_in;
   rank_type          victim_rank_ff, victim_rank_in;
   logic              free_ff, free_in;
   idx_type           free_idx_ff, free_idx_in;
   logic              hit_ff, hit_in;
   word_type          read_data_ff, read_data_in;
   logic              evicted_ff, evicted_in;
   word_type          evicted_key_ff, evicted_key_in;

   logic              out_free;
   logic              accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cap_reg_in      = csr_write_enable ? csr_write_data : cap_reg_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      idx_in          = idx_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      data_in         = data_ff;
      cap_in          = cap_ff;
      used_in         = used_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_data_in   = found_data_ff;
      found_count_in  = found_count_ff;
      found_rank_in   = found_rank_ff;
      victim_in       = victim_ff;
      victim_idx_in   = victim_idx_ff;
      victim_key_in   = victim_key_ff;
      victim_count_in = victim_count_ff;
      victim_rank_in  = victim_rank_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      hit_in          = hit_ff;
      read_data_in    = read_data_ff;
      evicted_in      = evicted_ff;
      evicted_key_in  = evicted_key_ff;
      wr_cmd          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               key_in    = word_type'(req_lookup_key);
               data_in   = word_type'(req_write_data);
               if (int'(cap_reg_ff) > NUM_ENTRIES) begin
                  cap_in = CAP_W'(NUM_ENTRIES);
               end else begin
                  cap_in = cap_reg_ff;
               end
               idx_in    = '0;
               used_in   = '0;
               found_in  = 1'b0;
               victim_in = 1'b0;
               free_in   = 1'b0;
               // A zero capacity skips the scan and answers with an all-zero result.
               state_in  = (cap_reg_ff == '0) ? ST_COMMIT : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (rd_entry.valid) begin
               used_in = used_ff + USED_W'(1);
            end
            if (key_match && !found_ff) begin
               found_in       = 1'b1;
               found_idx_in   = idx_ff;
               found_data_in  = rd_entry.data;
               found_count_in = rd_entry.count;
               found_rank_in  = rd_entry.rank;
            end
            if (better) begin
               victim_in       = 1'b1;
               victim_idx_in   = idx_ff;
               victim_key_in   = rd_entry.key;
               victim_count_in = rd_entry.count;
               victim_rank_in  = rd_entry.rank;
            end
            if (!rd_entry.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == IDX_LAST) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in = idx_ff + idx_type'(1);
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               hit_in         = 1'b0;
               read_data_in   = '0;
               evicted_in     = 1'b0;
               evicted_key_in = '0;
               wr_cmd.key     = key_ff;
               wr_cmd.data    = data_ff;
               wr_cmd.count   = count_type'(1);
               wr_cmd.rank_op = RANK_BELOW;
               wr_cmd.ref_rank = '0;
               if (cap_ff == '0) begin
                  wr_cmd.en = 1'b0;
               end else if (found_ff) begin
                  hit_in          = 1'b1;
                  wr_cmd.en       = 1'b1;
                  wr_cmd.slot     = found_idx_ff;
                  wr_cmd.ref_rank = found_rank_ff;
                  wr_cmd.count    = (found_count_ff == '1) ? found_count_ff
                                                           : found_count_ff + count_type'(1);
                  if (!op_ff) begin
                     read_data_in = found_data_ff;
                     wr_cmd.data  = found_data_ff;
                  end
               end else if (!op_ff) begin
                  wr_cmd.en = 1'b0;
               end else if (int'(used_ff) >= int'(cap_ff)) begin
                  // The victim's slot is reused; entries older than it keep their rank.
                  evicted_in      = 1'b1;
                  evicted_key_in  = victim_key_ff;
                  wr_cmd.en       = 1'b1;
                  wr_cmd.slot     = victim_idx_ff;
                  wr_cmd.ref_rank = victim_rank_ff;
               end else begin
                  wr_cmd.en      = 1'b1;
                  wr_cmd.slot    = free_idx_ff;
                  wr_cmd.rank_op = RANK_ALL;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_reg_ff   <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_reg_ff   <= cap_reg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      op_ff           <= op_in;
      key_ff          <= key_in;
      data_ff         <= data_in;
      cap_ff          <= cap_in;
      used_ff         <= used_in;
      found_ff        <= found_in;
      found_idx_ff    <= found_idx_in;
      found_data_ff   <= found_data_in;
      found_count_ff  <= found_count_in;
      found_rank_ff   <= found_rank_in;
      victim_ff       <= victim_in;
      victim_idx_ff   <= victim_idx_in;
      victim_key_ff   <= victim_key_in;
      victim_count_ff <= victim_count_in;
      victim_rank_ff  <= victim_rank_in;
      free_ff         <= free_in;
      free_idx_ff     <= free_idx_in;
      hit_ff          <= hit_in;
      read_data_ff    <= read_data_in;
      evicted_ff      <= evicted_in;
      evicted_key_ff  <= evicted_key_in;
   end

   assign rd_idx     = idx_ff;
   assign match_key  = key_ff;
   assign best_have  = victim_ff;
   assign best_count = victim_count_ff;
   assign best_rank  = victim_rank_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_data   = $signed(read_data_ff);
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = $signed(evicted_key_ff);

endmodule

// ===== rtl/lfu_cache_policy.sv =====
// Fully associative key-value cache with least-frequently-used replacement and
// least-recently-used tie-break. A request is a get (opcode 0) or a put (opcode 1)
// on a 32-bit key and gives exactly one response: hit, the stored value on a get
// hit, and the key of any entry evicted by a put on a new key. A request is first
// accepted; then the single store read port and the shared key and count/rank
// comparator walk the entries one after another, and the commit then updates
// the store and loads the response register; no new request is accepted before it.
// With a capacity of zero a request skips the walk and changes nothing. The commit
// waits while an earlier response is still stalled. The capacity register resets
// to 16, saturates at the number of entries and must be written only while idle.
// Reset clears all valid bits.
module lfu_cache_policy (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_lookup_key,
   input  logic signed [31:0] req_write_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_data,
   output logic               rsp_evicted,
   output logic signed [31:0] rsp_evicted_key,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data
);
   import lcp_pkg::*;

   idx_type    rd_idx;
   entry_type  rd_entry;
   word_type   match_key;
   logic       key_match;
   logic       better;
   logic       best_have;
   count_type  best_count;
   rank_type   best_rank;
   wr_cmd_type wr_cmd;

   lcp_control u_control (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_lookup_key   (req_lookup_key),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_data    (rsp_read_data),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rd_idx           (rd_idx),
      .rd_entry         (rd_entry),
      .match_key        (match_key),
      .key_match        (key_match),
      .better           (better),
      .best_have        (best_have),
      .best_count       (best_count),
      .best_rank        (best_rank),
      .wr_cmd           (wr_cmd)
   );

   lcp_match_unit u_match (
      .entry      (rd_entry),
      .key        (match_key),
      .best_have  (best_have),
      .best_count (best_count),
      .best_rank  (best_rank),
      .key_match  (key_match),
      .better     (better)
   );

   lcp_entry_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .wr_cmd   (wr_cmd)
   );

endmodule
